// ----- sv/fph_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and codes for the fit-policy heap allocator.
// No dependencies.
package fph_pkg;

    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEAP_BYTES   = 65536;
    localparam int DEF_HEADER_BYTES = 24;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'd1;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_NEXT  = 2'd1;
    localparam logic [1:0] FIT_BEST  = 2'd2;
    localparam logic [1:0] FIT_WORST = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NULL     = 2'd1;
    localparam logic [1:0] ST_NOMEM    = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    localparam logic [16:0] LIMIT_RESET = 17'd65536;

endpackage

// ----- sv/fph_req_if.sv -----
`timescale 1ns / 1ps
// Request channel: command, size and release address.
// Depends on nothing.
interface fph_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] req_size;
    logic [15:0] free_addr;

    modport source (output valid, output cmd, output req_size, output free_addr, input ready);
    modport sink   (input valid, input cmd, input req_size, input free_addr, output ready);
endinterface

// ----- sv/fph_rsp_if.sv -----
`timescale 1ns / 1ps
// Result channel: data address and status.
// Depends on nothing.
interface fph_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] data_addr;
    logic [1:0]  status;

    modport source (output valid, output data_addr, output status, input ready);
    modport sink   (input valid, input data_addr, input status, output ready);
endinterface

// ----- sv/fph_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: register index and data.
// Depends on fph_pkg for widths.
interface fph_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fph_pkg::CFG_IDX_W-1:0]  index;
    logic [fph_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/fph_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module fph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/fit_policy_heap_allocator.sv -----
`timescale 1ns / 1ps
// Heap allocator with first/next/best/worst fit, split and coalesce.
// Depends on fph_pkg, fph_req_if, fph_rsp_if, fph_cfg_if and fph_ram.
//
// Usage:
//  - req carries one request: cmd 0 allocates req_size bytes (rounded up
//    to a multiple of four), cmd 1 releases the block at data address
//    free_addr. rsp returns data_addr and status for every request.
//  - cfg writes fit_policy (index 0) and heap_limit (index 1); it is
//    always ready and must be used only while the block is idle.
//  - The block table (start, size, free) lives in one RAM, one entry
//    read and one written per cycle. A request reads the table entries
//    it scans (up to the entry count), then moves entries when a split
//    inserts or a merge removes entries, then does one or two final
//    writes. The worst case is best fit on a nearly full table that
//    splits its first entry. The single RAM port pair limits the pace.
//  - req is ready only while the sequencer is idle; a request can be
//    taken while the previous result still waits in the output register.
//  - If rsp stalls, the finished result waits until the output register
//    frees up; no result is lost.
//  - Reset empties the table (count, heap top, roving pointer to zero),
//    sets first fit and a 64 KiB limit. No RAM clearing pass is needed.
module fit_policy_heap_allocator
#(
    parameter int MAX_BLOCKS   = fph_pkg::DEF_MAX_BLOCKS,
    parameter int HEAP_BYTES   = fph_pkg::DEF_HEAP_BYTES,
    parameter int HEADER_BYTES = fph_pkg::DEF_HEADER_BYTES
) (
    input  logic      clk,
    input  logic      rst_n,
    fph_req_if.sink   req,
    fph_rsp_if.source rsp,
    fph_cfg_if.sink   cfg
);
    import fph_pkg::*;

    // widths
    localparam int IW   = $clog2(MAX_BLOCKS);
    localparam int CNTW = $clog2(MAX_BLOCKS + 1);
    localparam int XW   = CNTW + 1;               // index math headroom
    localparam int AW   = $clog2(HEAP_BYTES);     // block start
    localparam int SW   = AW + 1;                 // block size / heap top
    localparam int CW   = ((SW > 17) ? SW : 17) + 2;
    localparam int EW   = AW + SW + 1;            // {start, size, free}
    localparam int DAW  = ((AW + 1) > 16) ? (AW + 1) : 16;

    localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] HEAP_C  = CW'(HEAP_BYTES);
    localparam logic [XW-1:0] MAX_C   = XW'(MAX_BLOCKS);
    localparam logic [XW-1:0] ONE_X   = XW'(1);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_NEIGH  = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_FIN1   = 3'd5;
    localparam logic [2:0] S_FIN2   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic          cmd_reg, cmd_next;
    logic [16:0]   need_reg, need_next;
    logic [15:0]   addr_reg, addr_next;
    logic [XW-1:0] cur_reg, cur_next;
    logic [XW-1:0] k_reg, k_next;
    logic          found_reg, found_next;
    logic [XW-1:0] pick_reg, pick_next;
    logic [SW-1:0] pick_size_reg, pick_size_next;
    logic [AW-1:0] pick_start_reg, pick_start_next;
    logic [EW-1:0] hit_reg, hit_next;
    logic [EW-1:0] prev_reg, prev_next;
    logic [XW-1:0] sh_src_reg, sh_src_next;
    logic [XW-1:0] sh_end_reg, sh_end_next;
    logic          sh_ins_reg, sh_ins_next;
    logic [1:0]    sh_k_reg, sh_k_next;
    logic [XW-1:0] fa_idx_reg, fa_idx_next;
    logic [EW-1:0] fa_data_reg, fa_data_next;
    logic [XW-1:0] fb_idx_reg, fb_idx_next;
    logic [EW-1:0] fb_data_reg, fb_data_next;
    logic          fb_en_reg, fb_en_next;
    logic [15:0]   res_data_reg, res_data_next;
    logic [1:0]    res_status_reg, res_status_next;

    logic          out_valid_reg, out_valid_next;
    logic [15:0]   out_data_reg, out_data_next;
    logic [1:0]    out_status_reg, out_status_next;

    logic [XW-1:0] count_reg, count_next;
    logic [SW-1:0] top_reg, top_next;
    logic [XW-1:0] rover_reg, rover_next;
    logic [1:0]    policy_reg;
    logic [16:0]   limit_reg;

    // RAM port
    logic          ram_we;
    logic [XW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    fph_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr[IW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr[IW-1:0]),
        .rdata (ram_rdata)
    );

    // entry fields of the word coming out of the RAM
    logic [AW-1:0] rd_start;
    logic [SW-1:0] rd_size;
    logic          rd_free;
    assign rd_start = ram_rdata[EW-1 -: AW];
    assign rd_size  = ram_rdata[SW:1];
    assign rd_free  = ram_rdata[0];

    // data address of an entry start, masked to 16 bits
    function automatic logic [15:0] data_of(input logic [AW-1:0] st);
        logic [DAW-1:0] sum;
        sum = DAW'(st) + DAW'(HEADER_BYTES);
        return sum[15:0];
    endfunction

    // config port
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= FIT_FIRST;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FIT_POLICY: policy_reg <= cfg.data[1:0];
                CFG_HEAP_LIMIT: limit_reg  <= cfg.data;
                default:        ;
            endcase
        end
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.data_addr = out_data_reg;
    assign rsp.status    = out_status_reg;

    // scan helpers
    logic [XW-1:0] scan_nxt;
    logic          fits;
    logic [CW-1:0] need_cw;
    logic [XW-1:0] first_idx;
    assign need_cw   = CW'(need_reg);
    assign scan_nxt  = (cur_reg + ONE_X == count_reg) ? '0 : cur_reg + ONE_X;
    assign fits      = rd_free && (CW'(rd_size) >= need_cw);
    assign first_idx = (policy_reg == FIT_NEXT && rover_reg < count_reg) ? rover_reg : '0;

    // merge plan at the neighbor step
    logic          nb_next_free, nb_prev_free;
    logic [XW-1:0] rm_p;
    logic [1:0]    rm_k;
    logic [XW-1:0] rm_src;
    assign nb_next_free = (cur_reg + ONE_X < count_reg) && rd_free;
    assign nb_prev_free = (cur_reg != '0) && prev_reg[0];
    always_comb
    begin
        rm_p = cur_reg;
        rm_k = 2'd1;
        if (nb_next_free && nb_prev_free)
        begin
            rm_k = 2'd2;
        end
        else if (nb_next_free)
        begin
            rm_p = cur_reg + ONE_X;
        end
    end
    assign rm_src = rm_p + XW'(rm_k);

    always_comb
    begin
        logic [16:0]   need_in;
        logic [CW-1:0] leftover;
        logic [CW-1:0] grow_end;
        logic [CW-1:0] limit_cw;
        logic [CW-1:0] msum;
        logic [AW-1:0] split_start;
        logic          hit_free;

        state_next      = state_reg;
        cmd_next        = cmd_reg;
        need_next       = need_reg;
        addr_next       = addr_reg;
        cur_next        = cur_reg;
        k_next          = k_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        pick_size_next  = pick_size_reg;
        pick_start_next = pick_start_reg;
        hit_next        = hit_reg;
        prev_next       = prev_reg;
        sh_src_next     = sh_src_reg;
        sh_end_next     = sh_end_reg;
        sh_ins_next     = sh_ins_reg;
        sh_k_next       = sh_k_reg;
        fa_idx_next     = fa_idx_reg;
        fa_data_next    = fa_data_reg;
        fb_idx_next     = fb_idx_reg;
        fb_data_next    = fb_data_reg;
        fb_en_next      = fb_en_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        rover_next      = rover_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;

        need_in     = (17'(req.req_size) + 17'd3) & ~17'd3;
        leftover    = CW'(pick_size_reg) - need_cw;
        grow_end    = CW'(top_reg) + HDR_C + need_cw;
        limit_cw    = (CW'(limit_reg) < HEAP_C) ? CW'(limit_reg) : HEAP_C;
        split_start = AW'(CW'(pick_start_reg) + HDR_C + need_cw);
        hit_free    = hit_reg[0];
        msum        = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = (req.cmd == CMD_ALLOC) ? first_idx : '0;
                if (req.valid)
                begin
                    cmd_next        = req.cmd;
                    need_next       = need_in;
                    addr_next       = req.free_addr;
                    cur_next        = ram_raddr;
                    k_next          = '0;
                    found_next      = 1'b0;
                    res_data_next   = '0;
                    res_status_next = ST_OK;
                    if (req.cmd == CMD_ALLOC)
                    begin
                        if (need_in == '0)
                        begin
                            res_status_next = ST_NULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = (count_reg == '0) ? S_DECIDE : S_SCAN;
                        end
                    end
                    else
                    begin
                        if (req.free_addr == '0)
                        begin
                            res_status_next = ST_NULL;
                            state_next      = S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            res_status_next = ST_BAD_FREE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            // one table entry per cycle; ram_rdata holds entry cur_reg
            S_SCAN:
            begin
                ram_raddr = scan_nxt;
                cur_next  = scan_nxt;
                k_next    = k_reg + ONE_X;
                prev_next = ram_rdata;
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (fits && (!found_reg ||
                        (policy_reg == FIT_BEST  && rd_size < pick_size_reg) ||
                        (policy_reg == FIT_WORST && rd_size > pick_size_reg) ||
                        policy_reg == FIT_FIRST || policy_reg == FIT_NEXT))
                    begin
                        found_next      = 1'b1;
                        pick_next       = cur_reg;
                        pick_size_next  = rd_size;
                        pick_start_next = rd_start;
                    end
                    if ((fits && (policy_reg == FIT_FIRST || policy_reg == FIT_NEXT)) ||
                        (k_reg + ONE_X == count_reg))
                    begin
                        state_next = S_DECIDE;
                    end
                end
                else
                begin
                    if (data_of(rd_start) == addr_reg)
                    begin
                        // hold j and its predecessor; next entry arrives next cycle
                        hit_next   = ram_rdata;
                        prev_next  = prev_reg;
                        cur_next   = cur_reg;
                        state_next = S_NEIGH;
                    end
                    else if (k_reg + ONE_X == count_reg)
                    begin
                        res_status_next = ST_BAD_FREE;
                        state_next      = S_DONE;
                    end
                end
            end

            S_DECIDE:
            begin
                ram_raddr = count_reg - ONE_X;
                if (found_reg)
                begin
                    rover_next    = pick_reg + ONE_X;
                    res_data_next = data_of(pick_start_reg);
                    if (leftover > HDR_C + CW'(4) && count_reg < MAX_C)
                    begin
                        count_next   = count_reg + ONE_X;
                        fa_idx_next  = pick_reg + ONE_X;
                        fa_data_next = {split_start,
                                        SW'(leftover - HDR_C), 1'b1};
                        fb_idx_next  = pick_reg;
                        fb_data_next = {pick_start_reg, SW'(need_reg), 1'b0};
                        fb_en_next   = 1'b1;
                        if (count_reg > pick_reg + ONE_X)
                        begin
                            sh_src_next = count_reg - ONE_X;
                            sh_end_next = pick_reg + ONE_X;
                            sh_ins_next = 1'b1;
                            sh_k_next   = 2'd1;
                            state_next  = S_SHIFT;
                        end
                        else
                        begin
                            state_next = S_FIN1;
                        end
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = pick_reg;
                        ram_wdata  = {pick_start_reg, pick_size_reg, 1'b0};
                        state_next = S_DONE;
                    end
                end
                else if (count_reg < MAX_C && grow_end <= limit_cw)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = count_reg;
                    ram_wdata     = {AW'(top_reg), SW'(need_reg), 1'b0};
                    count_next    = count_reg + ONE_X;
                    rover_next    = count_reg + ONE_X;
                    top_next      = SW'(grow_end);
                    res_data_next = data_of(AW'(top_reg));
                    state_next    = S_DONE;
                end
                else
                begin
                    res_status_next = ST_NOMEM;
                    state_next      = S_DONE;
                end
            end

            // ram_rdata holds entry j+1 when it exists
            S_NEIGH:
            begin
                ram_raddr  = rm_src;
                fb_en_next = 1'b0;
                if (hit_free)
                begin
                    res_status_next = ST_BAD_FREE;
                    state_next      = S_DONE;
                end
                else if (!nb_next_free && !nb_prev_free)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = cur_reg;
                    ram_wdata  = {hit_reg[EW-1:1], 1'b1};
                    state_next = S_DONE;
                end
                else
                begin
                    if (nb_next_free && nb_prev_free)
                    begin
                        msum        = CW'(prev_reg[SW:1]) + CW'(hit_reg[SW:1]) +
                                      CW'(rd_size) + HDR_C + HDR_C;
                        fa_idx_next = cur_reg - ONE_X;
                        fa_data_next = {prev_reg[EW-1 -: AW], SW'(msum), 1'b1};
                    end
                    else if (nb_next_free)
                    begin
                        msum        = CW'(hit_reg[SW:1]) + CW'(rd_size) + HDR_C;
                        fa_idx_next = cur_reg;
                        fa_data_next = {hit_reg[EW-1 -: AW], SW'(msum), 1'b1};
                    end
                    else
                    begin
                        msum        = CW'(prev_reg[SW:1]) + CW'(hit_reg[SW:1]) + HDR_C;
                        fa_idx_next = cur_reg - ONE_X;
                        fa_data_next = {prev_reg[EW-1 -: AW], SW'(msum), 1'b1};
                    end
                    count_next = count_reg - XW'(rm_k);
                    if (rover_reg >= rm_src)
                    begin
                        rover_next = rover_reg - XW'(rm_k);
                    end
                    else if (rover_reg > rm_p)
                    begin
                        rover_next = rm_p;
                    end
                    if (rm_src < count_reg)
                    begin
                        sh_src_next = rm_src;
                        sh_end_next = count_reg - ONE_X;
                        sh_ins_next = 1'b0;
                        sh_k_next   = rm_k;
                        state_next  = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_FIN1;
                    end
                end
            end

            // move one entry a cycle: up by one for insert, down by k for removal
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                ram_waddr = sh_ins_reg ? sh_src_reg + ONE_X : sh_src_reg - XW'(sh_k_reg);
                ram_raddr = sh_ins_reg ? sh_src_reg - ONE_X : sh_src_reg + ONE_X;
                sh_src_next = ram_raddr;
                if (sh_src_reg == sh_end_reg)
                begin
                    state_next = S_FIN1;
                end
            end

            S_FIN1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = fa_idx_reg;
                ram_wdata  = fa_data_reg;
                state_next = fb_en_reg ? S_FIN2 : S_DONE;
            end

            S_FIN2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = fb_idx_reg;
                ram_wdata  = fb_data_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = res_data_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            top_reg       <= '0;
            rover_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            top_reg       <= top_next;
            rover_reg     <= rover_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        need_reg       <= need_next;
        addr_reg       <= addr_next;
        cur_reg        <= cur_next;
        k_reg          <= k_next;
        found_reg      <= found_next;
        pick_reg       <= pick_next;
        pick_size_reg  <= pick_size_next;
        pick_start_reg <= pick_start_next;
        hit_reg        <= hit_next;
        prev_reg       <= prev_next;
        sh_src_reg     <= sh_src_next;
        sh_end_reg     <= sh_end_next;
        sh_ins_reg     <= sh_ins_next;
        sh_k_reg       <= sh_k_next;
        fa_idx_reg     <= fa_idx_next;
        fa_data_reg    <= fa_data_next;
        fb_idx_reg     <= fb_idx_next;
        fb_data_reg    <= fb_data_next;
        fb_en_reg      <= fb_en_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

endmodule

// ----- test/fph_scoreboard.sv -----
`timescale 1ns / 1ps
// Scoreboard for the fit-policy heap allocator: block table predictor and
// the queue of expected results. Depends on fph_pkg.
package fph_scoreboard_pkg;
    import fph_pkg::*;

    typedef struct packed {
        logic [15:0] data_addr;
        logic [1:0]  status;
    } heap_result_t;

    class heap_scoreboard;
        int unsigned tab_start[DEF_MAX_BLOCKS];
        int unsigned tab_size[DEF_MAX_BLOCKS];
        bit          tab_free[DEF_MAX_BLOCKS];
        int unsigned count;
        int unsigned top;
        int unsigned roving;
        logic [1:0]  policy;
        int unsigned limit_reg;
        heap_result_t pending[$];
        int unsigned errors;
        // addresses currently handed out, for building well-formed releases
        int unsigned live[$];

        function new();
            count = 0; top = 0; roving = 0;
            policy = FIT_FIRST; limit_reg = LIMIT_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic idx, int unsigned value);
            if (idx == CFG_FIT_POLICY) policy = value[1:0];
            else limit_reg = value & 17'h1FFFF;
        endfunction

        function void drop_entry(int unsigned idx);
            for (int unsigned k = idx; k + 1 < count; k++)
            begin
                tab_start[k] = tab_start[k+1];
                tab_size[k] = tab_size[k+1];
                tab_free[k] = tab_free[k+1];
            end
            count--;
            if (roving > idx) roving--;
        endfunction

        function void add_entry(int unsigned idx, int unsigned s, int unsigned z);
            for (int unsigned k = count; k > idx; k--)
            begin
                tab_start[k] = tab_start[k-1];
                tab_size[k] = tab_size[k-1];
                tab_free[k] = tab_free[k-1];
            end
            tab_start[idx] = s; tab_size[idx] = z; tab_free[idx] = 1;
            count++;
            if (roving >= idx) roving++;
        endfunction

        function int pick_block(int unsigned need);
            int pick;
            int unsigned i, first;
            pick = -1;
            if (policy == FIT_NEXT)
            begin
                first = (roving < count) ? roving : 0;
                for (int unsigned k = 0; k < count; k++)
                begin
                    i = first + k;
                    if (i >= count) i -= count;
                    if (tab_free[i] && tab_size[i] >= need) return i;
                end
                return -1;
            end
            for (i = 0; i < count; i++)
            begin
                if (!tab_free[i] || tab_size[i] < need) continue;
                if (policy == FIT_FIRST) return i;
                if (pick < 0 || (policy == FIT_BEST && tab_size[i] < tab_size[pick]) ||
                    (policy == FIT_WORST && tab_size[i] > tab_size[pick]))
                    pick = i;
            end
            return pick;
        endfunction

        // note an accepted request and queue the result it must produce
        function void note_request(logic cmd, logic [15:0] size, logic [15:0] addr);
            heap_result_t r;
            int unsigned need, i, lim, j;
            int f;
            r.data_addr = 16'd0; r.status = ST_OK;
            if (cmd == CMD_ALLOC)
            begin
                need = (size + 3) & ~32'd3;
                if (need == 0) r.status = ST_NULL;
                else
                begin
                    f = pick_block(need);
                    if (f >= 0)
                    begin
                        i = f;
                        if (tab_size[i] - need > DEF_HEADER_BYTES + 4 && count < DEF_MAX_BLOCKS)
                        begin
                            add_entry(i + 1, tab_start[i] + DEF_HEADER_BYTES + need,
                                      tab_size[i] - need - DEF_HEADER_BYTES);
                            tab_size[i] = need;
                        end
                        tab_free[i] = 0;
                        roving = i + 1;
                        r.data_addr = 16'(tab_start[i] + DEF_HEADER_BYTES);
                    end
                    else
                    begin
                        lim = (limit_reg < DEF_HEAP_BYTES) ? limit_reg : DEF_HEAP_BYTES;
                        if (count < DEF_MAX_BLOCKS && top + DEF_HEADER_BYTES + need <= lim)
                        begin
                            tab_start[count] = top; tab_size[count] = need;
                            tab_free[count] = 0;
                            count++;
                            top += DEF_HEADER_BYTES + need;
                            roving = count;
                            r.data_addr = 16'(tab_start[count-1] + DEF_HEADER_BYTES);
                        end
                        else r.status = ST_NOMEM;
                    end
                end
                if (r.status == ST_OK) live.push_back(r.data_addr);
            end
            else if (addr == 0) r.status = ST_NULL;
            else
            begin
                for (j = 0; j < count; j++)
                    if (tab_start[j] + DEF_HEADER_BYTES == addr) break;
                if (j >= count || tab_free[j]) r.status = ST_BAD_FREE;
                else
                begin
                    tab_free[j] = 1;
                    if (j + 1 < count && tab_free[j+1])
                    begin
                        tab_size[j] += tab_size[j+1] + DEF_HEADER_BYTES;
                        drop_entry(j + 1);
                    end
                    if (j > 0 && tab_free[j-1])
                    begin
                        tab_size[j-1] += tab_size[j] + DEF_HEADER_BYTES;
                        drop_entry(j);
                    end
                    foreach (live[k])
                        if (live[k] == addr)
                        begin
                            live.delete(k);
                            break;
                        end
                end
            end
            pending.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(logic [15:0] addr, logic [1:0] st);
            heap_result_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result addr=%0d status=%0d", addr, st));
                return;
            end
            e = pending.pop_front();
            if (addr !== e.data_addr)
                report($sformatf("data_addr got %0d want %0d", addr, e.data_addr));
            if (st !== e.status)
                report($sformatf("status got %0d want %0d", st, e.status));
        endtask
    endclass
endpackage

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Top-level testbench for fit_policy_heap_allocator: drives requests and
// config writes, checks results. Depends on fph_pkg, the interfaces and
// fph_scoreboard_pkg.
module testbench;
    import fph_pkg::*;
    import fph_scoreboard_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2 * DEF_MAX_BLOCKS + 20;

    logic clk = 0;
    logic rst_n = 0;

    fph_req_if req();
    fph_rsp_if rsp();
    fph_cfg_if cfg();

    fit_policy_heap_allocator dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg));

    heap_scoreboard board;
    int unsigned idle_cycles;
    bit          hold_off;     // set by stimulus to ask for the long receiver stall
    bit          stim_done;

    always #5 clk = ~clk;

    initial
    begin
        board = new();
        req.valid = 0; req.cmd = 0; req.req_size = 0; req.free_addr = 0;
        rsp.ready = 0;
        cfg.valid = 0; cfg.index = 0; cfg.data = 0;
    end

    // gap length: mostly short, a few long, some stretches with none
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // monitor: note accepted requests, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
                board.note_request(req.cmd, req.req_size, req.free_addr);
            if (rsp.valid && rsp.ready)
                board.check_result(rsp.data_addr, rsp.status);
        end
    end

    // watchdog: cycles with no request or result accepted
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // receiver: random ready gaps; one long hold-off while requests pile up
    initial
    begin
        int unsigned g;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                rsp.ready <= 0;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            g = gap_len();
            if (g > 0)
            begin
                rsp.ready <= 0;
                repeat (g) @(posedge clk);
            end
            rsp.ready <= 1;
            @(posedge clk);
        end
    end

    task automatic send_request(logic cmd, logic [15:0] size, logic [15:0] addr);
        int unsigned g;
        g = gap_len();
        if (g > 0)
        begin
            req.valid <= 0;
            repeat (g) @(posedge clk);
        end
        req.valid <= 1; req.cmd <= cmd; req.req_size <= size; req.free_addr <= addr;
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic end_burst();
        req.valid <= 0;
        @(posedge clk);
    endtask

    // config writes only once all results have come back
    task automatic write_reg(logic idx, logic [16:0] value);
        end_burst();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg.valid <= 1; cfg.index <= idx; cfg.data <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 0;
        board.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic release_live();
        int unsigned k;
        logic [15:0] a;
        if (board.live.size() == 0)
        begin
            send_request(CMD_RELEASE, 16'($urandom), 16'($urandom_range(1, 65535)));
            return;
        end
        k = $urandom_range(0, board.live.size() - 1);
        a = 16'(board.live[k]);
        send_request(CMD_RELEASE, 16'($urandom), a);
    endtask

    function automatic logic [15:0] rand_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(1, 200));
        if (r < 90) return 16'($urandom_range(1, 2000));
        if (r < 95) return 16'd0;
        return 16'($urandom);
    endfunction

    initial
    begin
        logic [16:0] limits[5];
        int unsigned phase_items;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: null cases, extremes, double and unknown releases
        send_request(CMD_ALLOC, 16'd0, 16'hFFFF);
        send_request(CMD_RELEASE, 16'hFFFF, 16'd0);
        send_request(CMD_ALLOC, 16'd1, 16'd0);           // rounds to 4
        send_request(CMD_ALLOC, 16'd100, 16'd0);
        send_request(CMD_ALLOC, 16'd7, 16'd0);
        send_request(CMD_ALLOC, 16'd300, 16'd0);
        send_request(CMD_RELEASE, 16'd0, 16'd24 + 16'd4 + 16'd24);  // second block
        send_request(CMD_RELEASE, 16'd0, 16'd52);         // double release
        send_request(CMD_RELEASE, 16'd0, 16'd25);         // unknown address
        send_request(CMD_RELEASE, 16'd0, 16'hFFFF);
        send_request(CMD_ALLOC, 16'd8, 16'd0);            // split of the freed block
        send_request(CMD_RELEASE, 16'd0, 16'd24);         // release with no free neighbor
        send_request(CMD_ALLOC, 16'hFFFF, 16'd0);         // out of memory
        send_request(CMD_ALLOC, 16'hFFFD, 16'd0);
        // table full: many tiny allocations
        for (int i = 0; i < 66; i++) send_request(CMD_ALLOC, 16'd4, 16'd0);
        for (int i = 0; i < 10; i++) release_live();

        // extremes of the limit, each fit policy
        limits = '{17'd0, 17'd1000, 17'd70000, 17'h1FFFF, 17'd65536};
        write_reg(CFG_HEAP_LIMIT, 17'd0);
        send_request(CMD_ALLOC, 16'd500, 16'd0);
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_FIT_POLICY, 17'(ph % 4));
            write_reg(CFG_HEAP_LIMIT, limits[$urandom_range(1, 4)]);
            if (ph == 3) hold_off = 1;
            phase_items = 140;
            for (int n = 0; n < phase_items; n++)
            begin
                if ($urandom_range(0, 99) < 55)
                    send_request(CMD_ALLOC, rand_size(), 16'($urandom));
                else if ($urandom_range(0, 9) < 8) release_live();
                else send_request(CMD_RELEASE, 16'($urandom), 16'($urandom));
            end
        end
        write_reg(CFG_FIT_POLICY, 17'(FIT_NEXT));
        write_reg(CFG_HEAP_LIMIT, 17'd0);
        for (int n = 0; n < 20; n++) send_request(CMD_ALLOC, rand_size(), 16'd0);
        end_burst();

        while (board.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
